>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked outside reset only
`define FDMI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define FDMI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FDMI_ASSERT(name, clk, rst_n, prop, msg)

`define FDMI_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> rtl/fdmi_pkg.sv
`timescale 1ns / 1ps

package fdmi_pkg;

  // geometry, all powers of two
  localparam int CACHE_LINES    = 4;
  localparam int WORDS_PER_LINE = 16;
  localparam int CODE_WORDS     = 4096;

  localparam int PC_W        = 16;
  localparam int TAG_W       = 8;
  localparam int WORD_W      = 32;
  localparam int LAT_W       = 6;
  localparam int MISS_W      = 32;
  localparam int MEM_IDX_W   = 12;
  localparam int KIND_W      = 2;
  localparam int INSTR_WORDS = 4;
  localparam int BANK_SEL_W  = $clog2(INSTR_WORDS);

  localparam int LINE_W     = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int OFS_W      = $clog2(WORDS_PER_LINE);
  localparam int BLK_W      = PC_W - OFS_W;
  localparam int QUADS      = WORDS_PER_LINE / INSTR_WORDS;
  localparam int QUAD_W     = (QUADS > 1) ? $clog2(QUADS) : 1;
  localparam int BANK_DEPTH = CACHE_LINES * QUADS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CADDR_W    = $clog2(CODE_WORDS);
  localparam int FILL_CNT_W = $clog2(WORDS_PER_LINE + 1);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LATENCY = 1'd1;

  localparam logic [PC_W-1:0]  CODE_BASE_RST = 16'd384;
  localparam logic [LAT_W-1:0] MISS_LAT_RST  = 6'd47;

  // result kinds and bubble words
  localparam logic [KIND_W-1:0] KIND_INSTR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUBBLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SWITCH = 2'd2;
  localparam logic [WORD_W-1:0] BUBBLE_WORD = 32'd1;
  localparam logic [WORD_W-1:0] SWITCH_WORD = 32'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REFILL
  } fetch_st_t;

  typedef struct packed {
    logic                  en;
    logic [BANK_SEL_W-1:0] bank;
    logic [BANK_AW-1:0]    addr;
    logic [WORD_W-1:0]     data;
  } lstore_wr_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
  } lstore_rd_t;

  typedef logic [INSTR_WORDS-1:0][WORD_W-1:0] instr_t;

endpackage

>>> rtl/fdmi_in_if.sv
`timescale 1ns / 1ps

interface fdmi_in_if;
  import fdmi_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic        [MEM_IDX_W-1:0] mem_index;
  logic signed [WORD_W-1:0]    mem_data;
  logic                        stall_req;
  logic                        branch_valid;
  logic        [PC_W-1:0]      branch_target;
  logic                        context_switch;

  modport source (
    output valid, operation, mem_index, mem_data, stall_req, branch_valid,
           branch_target, context_switch,
    input  ready
  );

  modport sink (
    input  valid, operation, mem_index, mem_data, stall_req, branch_valid,
           branch_target, context_switch,
    output ready
  );

endinterface

>>> rtl/fdmi_out_if.sv
`timescale 1ns / 1ps

interface fdmi_out_if;
  import fdmi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [KIND_W-1:0] kind;
  logic signed [WORD_W-1:0] word_zero;
  logic signed [WORD_W-1:0] word_one;
  logic signed [WORD_W-1:0] word_two;
  logic signed [WORD_W-1:0] word_three;
  logic        [PC_W-1:0]   next_pc;
  logic        [MISS_W-1:0] miss_total;

  modport source (
    output valid, kind, word_zero, word_one, word_two, word_three, next_pc,
           miss_total,
    input  ready
  );

  modport sink (
    input  valid, kind, word_zero, word_one, word_two, word_three, next_pc,
           miss_total,
    output ready
  );

endinterface

>>> rtl/fetch_stage_direct_mapped_icache.sv
// channel   | dir | handshake          | carries
// in_ch     | in  | valid/ready        | fetch cycle or code memory load
// out_ch    | out | valid/ready        | instruction or bubble, pc, miss total
// cfg_*     | in  | cfg_we, no wait    | code_base, miss_latency
//
// a load, a bubble or a stalled cycle is done in ST_IDLE; a cache hit also
// passes through ST_LOOKUP (registered read of the line store banks)
// the last count of a miss starts a line refill: 16 reads through the
// single code memory read port, each written back; no transfer taken meanwhile
// a result waits in the output register; a new item is taken in the cycle
// that register empties
// rst_n is synchronous; cache data and code memory are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fetch_stage_direct_mapped_icache (
  input  logic                                clk,
  input  logic                                rst_n,
  fdmi_in_if.sink                             in_ch,
  fdmi_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [fdmi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdmi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fdmi_pkg::*;

  fetch_st_t state_r, state_nxt;

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [LAT_W-1:0]  countdown_r, countdown_nxt;
  logic              sent_r, sent_nxt;
  logic [MISS_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [PC_W-1:0]   code_base_r;
  logic [LAT_W-1:0]  miss_lat_r;
  logic [TAG_W-1:0]  tag_r [CACHE_LINES];
  logic [CACHE_LINES-1:0] valid_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  instr_t            out_words_r, out_words_nxt;
  logic [PC_W-1:0]   out_pc_r, out_pc_nxt;
  logic [MISS_W-1:0] out_miss_r, out_miss_nxt;
  logic              out_load;

  logic [FILL_CNT_W-1:0] fill_cnt_r;
  logic [BLK_W-1:0]      fill_blk_r;
  logic                  fill_wr_en_r;
  logic [OFS_W-1:0]      fill_j_r;
  logic [WORD_W-1:0]     code_q_r;
  logic [WORD_W-1:0]     code_mem [CODE_WORDS];

  logic              in_xfer, is_fetch, is_load, counting;
  logic [PC_W-1:0]   pc_b, off;
  logic [BLK_W-1:0]  blk;
  logic [LINE_W-1:0] line, fill_line;
  logic [QUAD_W-1:0] quad;
  logic              hit, start_fill, code_re;
  logic [CADDR_W-1:0] code_raddr, code_waddr;
  lstore_wr_t        ls_wr;
  lstore_rd_t        ls_rd;
  instr_t            ls_data;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_fetch    = in_xfer && !in_ch.operation;
  assign is_load     = in_xfer && in_ch.operation;

  // lookup address after any branch redirect
  assign pc_b     = in_ch.branch_valid ? in_ch.branch_target : pc_r;
  assign off      = pc_b - code_base_r;
  assign blk      = off[PC_W-1:OFS_W];
  assign line     = LINE_W'(blk % CACHE_LINES);
  assign quad     = QUAD_W'((off % WORDS_PER_LINE) / INSTR_WORDS);
  assign hit      = valid_r[line] && (tag_r[line] == blk[TAG_W-1:0]);
  assign counting = (countdown_r != '0) && !in_ch.branch_valid;
  assign start_fill = is_fetch && counting && (countdown_r == LAT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_fetch && !counting && !in_ch.stall_req && !in_ch.context_switch && hit) begin
          state_nxt = ST_LOOKUP;
        end else if (start_fill) begin
          state_nxt = ST_REFILL;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_IDLE;
      end
      ST_REFILL: begin
        if (fill_cnt_r == FILL_CNT_W'(WORDS_PER_LINE)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fetch decisions and result
  always_comb begin
    pc_nxt        = pc_r;
    countdown_nxt = countdown_r;
    sent_nxt      = sent_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_load      = 1'b0;
    out_kind_nxt  = KIND_BUBBLE;
    out_words_nxt = '0;
    out_pc_nxt    = pc_r;
    out_miss_nxt  = miss_cnt_r;
    ls_rd.en      = 1'b0;
    ls_rd.addr    = BANK_AW'(32'(line) * QUADS + 32'(quad));
    unique case (state_r)
      ST_IDLE: begin
        if (is_fetch) begin
          if (!in_ch.context_switch) begin
            sent_nxt = 1'b0;
          end
          pc_nxt = pc_b;
          priority if (counting) begin
            countdown_nxt    = countdown_r - LAT_W'(1);
            out_load         = 1'b1;
            out_words_nxt[0] = BUBBLE_WORD;
          end else if (in_ch.stall_req) begin
            // stalled: pc updated, countdown kept, no result
          end else if (in_ch.context_switch) begin
            countdown_nxt = '0;
            out_load      = 1'b1;
            if (!sent_r) begin
              sent_nxt         = 1'b1;
              out_kind_nxt     = KIND_SWITCH;
              out_words_nxt[0] = SWITCH_WORD;
            end else begin
              out_words_nxt[0] = BUBBLE_WORD;
            end
          end else if (hit) begin
            countdown_nxt = '0;
            pc_nxt        = pc_b + PC_W'(INSTR_WORDS);
            ls_rd.en      = 1'b1;
          end else begin
            countdown_nxt    = miss_lat_r;
            miss_cnt_nxt     = miss_cnt_r + MISS_W'(1);
            out_load         = 1'b1;
            out_words_nxt[0] = BUBBLE_WORD;
          end
          out_pc_nxt   = pc_nxt;
          out_miss_nxt = miss_cnt_nxt;
        end
      end
      ST_LOOKUP: begin
        out_load      = 1'b1;
        out_kind_nxt  = KIND_INSTR;
        out_words_nxt = ls_data;
      end
      ST_REFILL: begin
      end
      default: begin
      end
    endcase
  end

  // refill sweep: read code memory word by word, write from the read register
  assign code_re    = (state_r == ST_REFILL) && (fill_cnt_r < FILL_CNT_W'(WORDS_PER_LINE));
  assign code_raddr = CADDR_W'((32'(fill_blk_r) * WORDS_PER_LINE
                               + 32'(fill_cnt_r[OFS_W-1:0])) % CODE_WORDS);
  assign code_waddr = CADDR_W'(32'(in_ch.mem_index) % CODE_WORDS);
  assign fill_line  = LINE_W'(fill_blk_r % CACHE_LINES);

  assign ls_wr.en   = fill_wr_en_r;
  assign ls_wr.bank = BANK_SEL_W'(fill_j_r % INSTR_WORDS);
  assign ls_wr.addr = BANK_AW'(32'(fill_line) * QUADS + 32'(fill_j_r) / INSTR_WORDS);
  assign ls_wr.data = code_q_r;

  always_ff @(posedge clk) begin
    if (is_load) begin
      code_mem[code_waddr] <= in_ch.mem_data;
    end
    if (code_re) begin
      code_q_r <= code_mem[code_raddr];
    end
  end

  fdmi_line_store u_line_store (
    .clk       (clk),
    .wr        (ls_wr),
    .rd        (ls_rd),
    .rd_data_r (ls_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= CODE_BASE_RST;
      countdown_r  <= '0;
      sent_r       <= 1'b0;
      miss_cnt_r   <= '0;
      code_base_r  <= CODE_BASE_RST;
      miss_lat_r   <= MISS_LAT_RST;
      valid_r      <= '0;
      fill_cnt_r   <= '0;
      fill_wr_en_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < CACHE_LINES; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      countdown_r  <= countdown_nxt;
      sent_r       <= sent_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
      fill_wr_en_r <= code_re;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CODE_BASE:    code_base_r <= cfg_data[PC_W-1:0];
          CFG_MISS_LATENCY: miss_lat_r  <= cfg_data[LAT_W-1:0];
        endcase
      end
      if (start_fill) begin
        tag_r[line]   <= blk[TAG_W-1:0];
        valid_r[line] <= 1'b1;
        fill_cnt_r    <= '0;
      end else if (code_re) begin
        fill_cnt_r <= fill_cnt_r + FILL_CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_fill) begin
      fill_blk_r <= blk;
    end
    fill_j_r <= fill_cnt_r[OFS_W-1:0];
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_words_r <= out_words_nxt;
      out_pc_r    <= out_pc_nxt;
      out_miss_r  <= out_miss_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.word_zero  = out_words_r[0];
  assign out_ch.word_one   = out_words_r[1];
  assign out_ch.word_two   = out_words_r[2];
  assign out_ch.word_three = out_words_r[3];
  assign out_ch.next_pc    = out_pc_r;
  assign out_ch.miss_total = out_miss_r;

  `FDMI_ASSERT(a_lookup_gives_result, clk, rst_n, state_r == ST_LOOKUP |=> out_valid_r, "hit read did not produce a result")
  `FDMI_ASSERT(a_refill_after_last_count, clk, rst_n, state_r == ST_REFILL |-> countdown_r == '0, "refill running with miss still pending")
  `FDMI_ASSERT(a_no_hit_during_miss, clk, rst_n, countdown_r != '0 |-> state_r != ST_LOOKUP, "cache read while a miss is pending")
  `FDMI_ASSERT(a_miss_counted_with_bubble, clk, rst_n, miss_cnt_r != $past(miss_cnt_r) |-> out_valid_r && out_kind_r == KIND_BUBBLE, "miss counted without a bubble")
  `FDMI_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid_r && state_r == ST_IDLE && countdown_r == '0, "state not cleared by reset")

endmodule

>>> rtl/fdmi_line_store.sv
`timescale 1ns / 1ps

// cache data: one bank per word of an instruction, all read at one address
module fdmi_line_store (
  input  logic                clk,
  input  fdmi_pkg::lstore_wr_t wr,
  input  fdmi_pkg::lstore_rd_t rd,
  output fdmi_pkg::instr_t     rd_data_r
);
  import fdmi_pkg::*;

  for (genvar g = 0; g < INSTR_WORDS; g++) begin : g_bank
    logic [WORD_W-1:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr.en && wr.bank == BANK_SEL_W'(g)) begin
        mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
        rd_data_r[g] <= mem[rd.addr];
      end
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fdmi_pkg::*;

  localparam logic OP_FETCH = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  // code memory words preloaded around offset zero, some of them below it
  localparam int PRELOAD_WORDS = 512;
  localparam int PRELOAD_BELOW = 128;
  // lookups stay in this offset window, so every refill reads preloaded words
  localparam int OFS_LOW  = -64;
  localparam int OFS_HIGH = 320;

  typedef struct packed {
    logic                 operation;
    logic [MEM_IDX_W-1:0] mem_index;
    logic [WORD_W-1:0]    mem_data;
    logic                 stall_req;
    logic                 branch_valid;
    logic [PC_W-1:0]      branch_target;
    logic                 context_switch;
  } fetch_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word_zero;
    logic [WORD_W-1:0] word_one;
    logic [WORD_W-1:0] word_two;
    logic [WORD_W-1:0] word_three;
    logic [PC_W-1:0]   next_pc;
    logic [MISS_W-1:0] miss_total;
  } fetch_out_t;

  typedef struct {
    fetch_in_t        cmd;
    bit               typed;
    bit               has_out;
    fetch_out_t       out;
    bit               reconfig;
    logic [PC_W-1:0]  new_base;
    logic [LAT_W-1:0] new_lat;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fdmi_in_if  in_ch ();
  fdmi_out_if out_ch ();

  fetch_stage_direct_mapped_icache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // fetch stage state as the testbench sees it
  logic [PC_W-1:0]   model_base;
  logic [LAT_W-1:0]  model_latency;
  logic [PC_W-1:0]   model_pc;
  logic [LAT_W-1:0]  model_countdown;
  logic              model_sent;
  logic [MISS_W-1:0] model_misses;
  logic [WORD_W-1:0] line_data [CACHE_LINES][WORDS_PER_LINE];
  logic [TAG_W-1:0]  line_tag [CACHE_LINES];
  logic              line_ok [CACHE_LINES];
  logic [WORD_W-1:0] code_mem [CODE_WORDS];

  fetch_out_t fetch_out_due [$];

  int  errors = 0;
  int  transfers_in = 0;
  int  results_checked = 0;
  int  hit_count = 0;
  int  cycle_count = 0;
  int  gap_pct = 0;
  int  stall_pct = 0;
  int  switch_run = 0;
  bit  hold_req = 1'b0;

  function automatic void reset_model();
    model_base      = CODE_BASE_RST;
    model_latency   = MISS_LAT_RST;
    model_pc        = CODE_BASE_RST;
    model_countdown = '0;
    model_sent      = 1'b0;
    model_misses    = '0;
    for (int l = 0; l < CACHE_LINES; l++) begin
      line_tag[l] = '0;
      line_ok[l]  = 1'b0;
    end
  endfunction

  function automatic logic [PC_W-1:0] pc_offset();
    return model_pc - model_base;
  endfunction

  function automatic fetch_out_t make_out(input logic [KIND_W-1:0] kind,
                                          input logic [WORD_W-1:0] w0, w1, w2, w3);
    fetch_out_t o;
    o.kind       = kind;
    o.word_zero  = w0;
    o.word_one   = w1;
    o.word_two   = w2;
    o.word_three = w3;
    o.next_pc    = model_pc;
    o.miss_total = model_misses;
    return o;
  endfunction

  // one item through the fetch stage: load, branch, miss countdown, stall, switch, lookup
  function automatic bit step_fetch_stage(input fetch_in_t it, output fetch_out_t res);
    logic [PC_W-1:0] ofs;
    int blk;
    int line;
    int slot;
    res = '0;
    if (it.operation == OP_LOAD) begin
      code_mem[it.mem_index] = it.mem_data;
      return 1'b0;
    end
    if (!it.context_switch) model_sent = 1'b0;
    if (it.branch_valid) model_pc = it.branch_target;
    if (model_countdown != 0 && !it.branch_valid) begin
      // last count of the penalty brings the line in
      if (model_countdown == 1) begin
        blk  = pc_offset() / WORDS_PER_LINE;
        line = blk % CACHE_LINES;
        line_tag[line] = blk[TAG_W-1:0];
        line_ok[line]  = 1'b1;
        for (int j = 0; j < WORDS_PER_LINE; j++) begin
          line_data[line][j] = code_mem[(blk * WORDS_PER_LINE + j) % CODE_WORDS];
        end
      end
      model_countdown = model_countdown - 1'b1;
      res = make_out(KIND_BUBBLE, BUBBLE_WORD, '0, '0, '0);
      return 1'b1;
    end
    if (it.stall_req) return 1'b0;
    model_countdown = '0;
    if (it.context_switch) begin
      if (!model_sent) begin
        model_sent = 1'b1;
        res = make_out(KIND_SWITCH, SWITCH_WORD, '0, '0, '0);
      end else begin
        res = make_out(KIND_BUBBLE, BUBBLE_WORD, '0, '0, '0);
      end
      return 1'b1;
    end
    ofs  = pc_offset();
    blk  = ofs / WORDS_PER_LINE;
    line = blk % CACHE_LINES;
    if (line_ok[line] && line_tag[line] == blk[TAG_W-1:0]) begin
      slot = ((ofs % WORDS_PER_LINE) / INSTR_WORDS) * INSTR_WORDS;
      model_pc = model_pc + INSTR_WORDS;
      hit_count++;
      res = make_out(KIND_INSTR, line_data[line][slot],
                     line_data[line][(slot + 1) % WORDS_PER_LINE],
                     line_data[line][(slot + 2) % WORDS_PER_LINE],
                     line_data[line][(slot + 3) % WORDS_PER_LINE]);
      return 1'b1;
    end
    model_countdown = model_latency;
    model_misses    = model_misses + 1'b1;
    res = make_out(KIND_BUBBLE, BUBBLE_WORD, '0, '0, '0);
    return 1'b1;
  endfunction

  function automatic fetch_out_t bubble_out(input logic [PC_W-1:0] pc,
                                            input logic [MISS_W-1:0] misses);
    return '{KIND_BUBBLE, BUBBLE_WORD, '0, '0, '0, pc, misses};
  endfunction

  function automatic fetch_in_t fetch_cmd(input logic stall, input logic br,
                                          input logic [PC_W-1:0] target,
                                          input logic ctx);
    return '{OP_FETCH, '0, '0, stall, br, target, ctx};
  endfunction

  function automatic fetch_in_t load_cmd(input logic [MEM_IDX_W-1:0] idx,
                                         input logic [WORD_W-1:0] data);
    return '{OP_LOAD, idx, data, 1'b0, 1'b0, '0, 1'b0};
  endfunction

  function automatic dir_row_t row(input fetch_in_t cmd, input bit typed,
                                   input bit has_out, input fetch_out_t out);
    return '{cmd: cmd, typed: typed, has_out: has_out, out: out,
             reconfig: 1'b0, new_base: '0, new_lat: '0};
  endfunction

  // mostly plain fetches so that lines fill and hit; the rest is noise
  function automatic fetch_in_t random_cmd(input logic [PC_W-1:0] base);
    fetch_in_t c;
    int pick;
    int ofs;
    c.operation      = OP_FETCH;
    c.mem_index      = MEM_IDX_W'($urandom);
    c.mem_data       = $urandom;
    c.stall_req      = 1'b0;
    c.branch_valid   = 1'b0;
    c.branch_target  = PC_W'($urandom);
    c.context_switch = 1'b0;
    pick = $urandom_range(0, 99);
    if (switch_run != 0) begin
      switch_run--;
      c.context_switch = 1'b1;
      c.stall_req      = ($urandom_range(0, 7) == 0);
    end else if (pick < 5) begin
      c.operation = OP_LOAD;
      {c.stall_req, c.branch_valid, c.context_switch} = 3'($urandom);
    end else if (pick < 13) begin
      c.branch_valid = 1'b1;
      // near the code base, a little below it too, so that lines get reused and conflict
      c.branch_target = base + PC_W'($urandom_range(0, 191)) - PC_W'(64);
      c.stall_req = ($urandom_range(0, 3) == 0);
    end else if (pick < 20) begin
      c.stall_req = 1'b1;
    end else if (pick < 24) begin
      c.context_switch = 1'b1;
      switch_run = $urandom_range(0, 3);
    end
    // pull the pc back to the code base once it leaves the lookup window
    ofs = int'($signed(pc_offset()));
    if (c.operation == OP_FETCH && !c.branch_valid && (ofs < OFS_LOW || ofs >= OFS_HIGH)) begin
      c.branch_valid  = 1'b1;
      c.branch_target = base;
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic offer(input fetch_in_t it, input bit typed, input bit typed_has,
                       input fetch_out_t typed_out);
    fetch_out_t res;
    bit has;
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= it.operation;
    in_ch.mem_index      <= it.mem_index;
    in_ch.mem_data       <= it.mem_data;
    in_ch.stall_req      <= it.stall_req;
    in_ch.branch_valid   <= it.branch_valid;
    in_ch.branch_target  <= it.branch_target;
    in_ch.context_switch <= it.context_switch;
    do @(posedge clk); while (!in_ch.ready);
    transfers_in++;
    has = step_fetch_stage(it, res);
    if (typed) begin
      has = typed_has;
      res = typed_out;
    end
    if (has) fetch_out_due.push_back(res);
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (fetch_out_due.size() != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_CODE_BASE) model_base = data[PC_W-1:0];
    else model_latency = data[LAT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // drain, let any refill finish, then reprogram
  task automatic set_config(input logic [PC_W-1:0] base, input logic [LAT_W-1:0] lat);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_cfg(CFG_CODE_BASE, CFG_DATA_W'(base));
    write_cfg(CFG_MISS_LATENCY, CFG_DATA_W'(lat));
  endtask

  task automatic run_phase(input logic [PC_W-1:0] base, input logic [LAT_W-1:0] lat,
                           input int items, input int gaps, input int stalls,
                           input bit long_hold);
    set_config(base, lat);
    gap_pct   = gaps;
    stall_pct = stalls;
    switch_run = 0;
    for (int n = 0; n < items; n++) begin
      if (long_hold && n == 10) hold_req = 1'b1;
      if (n == items / 2) wait_results_done();
      offer(random_cmd(base), 1'b0, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin : watch_results
    fetch_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fetch_out_due.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d pc %h",
               out_ch.kind, out_ch.next_pc);
        errors++;
      end else begin
        want = fetch_out_due.pop_front();
        results_checked++;
        check_field("kind", WORD_W'(want.kind), WORD_W'(out_ch.kind));
        check_field("word_zero", want.word_zero, out_ch.word_zero);
        check_field("word_one", want.word_one, out_ch.word_one);
        check_field("word_two", want.word_two, out_ch.word_two);
        check_field("word_three", want.word_three, out_ch.word_three);
        check_field("next_pc", WORD_W'(want.next_pc), WORD_W'(out_ch.next_pc));
        check_field("miss_total", want.miss_total, out_ch.miss_total);
      end
    end
  end

  // receiver side: short random hold-offs, plus one long one on request
  initial begin : result_ready
    int hold_len;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      hold_len = 0;
      if (hold_req) begin
        hold_len = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold_len = $urandom_range(1, 9);
      end
      @(negedge clk);
      if (hold_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    dir_row_t rows [$];
    fetch_out_t none;
    none = '0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_FETCH;
    in_ch.mem_index      = '0;
    in_ch.mem_data       = '0;
    in_ch.stall_req      = 1'b0;
    in_ch.branch_valid   = 1'b0;
    in_ch.branch_target  = '0;
    in_ch.context_switch = 1'b0;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // code memory is not cleared, so fill the words around offset zero that lookups reach
    for (int i = 0; i < PRELOAD_WORDS; i++) begin
      offer(load_cmd(MEM_IDX_W'(i - PRELOAD_BELOW), $urandom), 1'b0, 1'b0, none);
    end

    // reset settings: code base 384 and the reset miss penalty
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 1, 1, bubble_out(16'd384, 1)));
    rows.push_back(row(fetch_cmd(1'b1, 1'b0, 16'h0000, 1'b0), 1, 1, bubble_out(16'd384, 1)));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b1), 1, 1, bubble_out(16'd384, 1)));
    // branch with stall keeps the pending miss
    rows.push_back(row(fetch_cmd(1'b1, 1'b1, 16'h0000, 1'b0), 1, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 1, 1, bubble_out(16'h0000, 1)));
    // branch without stall drops the miss and looks up again
    rows.push_back(row(fetch_cmd(1'b0, 1'b1, 16'hFFFF, 1'b0), 1, 1, bubble_out(16'hFFFF, 2)));
    rows.push_back(row(load_cmd(12'hFFF, 32'h8000_0000), 1, 0, none));
    rows.push_back(row(load_cmd(12'h000, 32'h7FFF_FFFF), 1, 0, none));
    // code base 0 and a new miss latency setting
    rows.push_back('{cmd: fetch_cmd(1'b0, 1'b1, 16'h0000, 1'b0), typed: 0, has_out: 0,
                     out: none, reconfig: 1'b1, new_base: 16'h0000, new_lat: 6'd1});
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b1), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b1), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b1, 1'b0, 16'h0000, 1'b1), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b1), 0, 0, none));
    // unaligned pc inside a line
    rows.push_back(row(fetch_cmd(1'b0, 1'b1, 16'd13, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    // top of the pc range, the hit wraps the pc past zero
    rows.push_back(row(fetch_cmd(1'b0, 1'b1, 16'hFFFF, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));
    rows.push_back(row(fetch_cmd(1'b0, 1'b0, 16'h0000, 1'b0), 0, 0, none));

    gap_pct   = 10;
    stall_pct = 10;
    foreach (rows[i]) begin
      if (rows[i].reconfig) set_config(rows[i].new_base, rows[i].new_lat);
      offer(rows[i].cmd, rows[i].typed, rows[i].has_out, rows[i].out);
    end

    run_phase(16'hFFFF, 6'd63, 100, 25, 12, 1'b0);
    run_phase(PC_W'($urandom), 6'd0, 50, 10, 8, 1'b0);
    run_phase(PC_W'($urandom), LAT_W'($urandom_range(1, 4)), 200, 20, 10, 1'b1);
    run_phase(PC_W'($urandom), LAT_W'($urandom_range(1, 8)), 150, 5, 30, 1'b0);
    run_phase(CODE_BASE_RST, 6'd2, 80, 0, 0, 1'b0);

    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d input transfers (loads and fetch cycles), %0d results checked",
             transfers_in, results_checked);
    $display("%0d cache hits and %0d misses predicted over seven settings",
             hit_count, model_misses);
    if (errors == 0 && fetch_out_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
